FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mcsp_pkg.sv
package mcsp_pkg;

  // Default geometry of the card store.
  localparam int unsigned NumSectorsDef  = 1024;
  localparam int unsigned SectorBytesDef = 128;
  localparam int unsigned SectorW        = 16;

  // Action codes on the input word.
  localparam logic [1:0] ACT_EXCHANGE = 2'd0;
  localparam logic [1:0] ACT_SELECT   = 2'd1;
  localparam logic [1:0] ACT_INSERT   = 2'd2;

  // Protocol bytes.
  localparam logic [7:0] CMD_READ    = 8'h52;
  localparam logic [7:0] CMD_WRITE   = 8'h57;
  localparam logic [7:0] ID_HI       = 8'h5A;
  localparam logic [7:0] ID_LO       = 8'h5D;
  localparam logic [7:0] CMD_ACK1    = 8'h5C;
  localparam logic [7:0] CMD_ACK2    = 8'h5D;
  localparam logic [7:0] END_GOOD    = 8'h47;
  localparam logic [7:0] END_BAD_SUM = 8'h4E;
  localparam logic [7:0] BYTE_NONE   = 8'hFF;
  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] FLAG_NEW    = 8'h08;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] host_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] response_byte;
    logic       ack;
  } out_item_t;

  // Store write request from the sequencer.
  typedef struct packed {
    logic       we;
    logic [7:0] wdata;
  } mem_ctl_t;

endpackage

FILE: rtl/core/mcsp_ram.sv
module mcsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/mcsp_seq.sv
module mcsp_seq import mcsp_pkg::*; #(
  parameter int unsigned NUM_SECTORS  = NumSectorsDef,
  parameter int unsigned SECTOR_BYTES = SectorBytesDef,
  parameter int unsigned ADDR_W       = $clog2(NumSectorsDef * SectorBytesDef)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  in_item_t          item_i,
  input  logic [7:0]        rdata_i,
  output out_item_t         result_o,
  output mem_ctl_t          mem_o,
  output logic [ADDR_W-1:0] addr_o
);

  localparam int unsigned BiW = (SECTOR_BYTES > 1) ? $clog2(SECTOR_BYTES) : 1;
  localparam logic [BiW-1:0]     ByteLast = BiW'(SECTOR_BYTES - 1);
  localparam logic [SectorW:0]   NumSecW  = (SectorW + 1)'(NUM_SECTORS);
  localparam int unsigned        ProdW    = SectorW + 8;

  // Sequence steps.
  localparam logic [3:0] ST_FLAG    = 4'd0;
  localparam logic [3:0] ST_ID1     = 4'd1;
  localparam logic [3:0] ST_ID2     = 4'd2;
  localparam logic [3:0] ST_SEC_HI  = 4'd3;
  localparam logic [3:0] ST_SEC_LO  = 4'd4;
  localparam logic [3:0] RD_ACK1    = 4'd5;
  localparam logic [3:0] RD_ACK2    = 4'd6;
  localparam logic [3:0] RD_CONF_HI = 4'd7;
  localparam logic [3:0] RD_CONF_LO = 4'd8;
  localparam logic [3:0] RD_DATA    = 4'd9;
  localparam logic [3:0] RD_SUM     = 4'd10;
  localparam logic [3:0] RD_END     = 4'd11;
  localparam logic [3:0] WR_DATA    = 4'd5;
  localparam logic [3:0] WR_SUM     = 4'd6;
  localparam logic [3:0] WR_ACK1    = 4'd7;
  localparam logic [3:0] WR_ACK2    = 4'd8;
  localparam logic [3:0] WR_END     = 4'd9;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_e;

  mode_e              mode_q, mode_d, eff_mode;
  logic [3:0]         step_q, step_d, eff_step;
  logic [7:0]         flag_q, flag_d;
  logic [7:0]         prev_q, prev_d;
  logic [SectorW-1:0] sector_q, sector_d, sector_or;
  logic [BiW-1:0]     bidx_q, bidx_d;
  logic [7:0]         csum_q, csum_d;
  logic               good_q, good_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [ProdW-1:0]   base_addr;
  logic               sec_valid;
  logic [7:0]         v;
  out_item_t          res;
  mem_ctl_t           mem;

  assign v         = item_i.host_byte;
  assign sec_valid = {1'b0, sector_q} < NumSecW;

  // Sector start address, formed when the low sector byte arrives.
  assign sector_or = sector_q | {8'h00, v};
  assign base_addr = ProdW'(sector_or) * ProdW'(SECTOR_BYTES);

  // Next state and reply for the word held in the execute slot.
  always_comb begin
    mode_d   = mode_q;
    step_d   = step_q;
    flag_d   = flag_q;
    prev_d   = prev_q;
    sector_d = sector_q;
    bidx_d   = bidx_q;
    csum_d   = csum_q;
    good_d   = good_q;
    addr_d   = addr_q;
    res.response_byte = BYTE_NONE;
    res.ack  = 1'b0;
    mem.we   = 1'b0;
    mem.wdata = v;

    // A command byte in idle starts its sequence at the flag step.
    eff_mode = mode_q;
    eff_step = step_q;
    if (mode_q == MODE_IDLE && v == CMD_READ) begin
      eff_mode = MODE_READ;
      eff_step = ST_FLAG;
    end else if (mode_q == MODE_IDLE && v == CMD_WRITE) begin
      eff_mode = MODE_WRITE;
      eff_step = ST_FLAG;
    end

    case (item_i.action)
      ACT_EXCHANGE: begin
        prev_d = v;
        if (eff_mode == MODE_IDLE) begin
          // rejected command: no ack, stay idle
        end else if ((eff_mode == MODE_READ || eff_mode == MODE_WRITE) &&
                     eff_step <= ST_SEC_LO) begin
          // header shared by read and write
          mode_d  = eff_mode;
          step_d  = eff_step + 4'd1;
          res.ack = 1'b1;
          case (eff_step)
            ST_FLAG: begin
              res.response_byte = flag_q;
              bidx_d = '0;
              csum_d = BYTE_ZERO;
              if (eff_mode == MODE_WRITE) begin
                flag_d = flag_q & ~FLAG_NEW;
              end
            end
            ST_ID1: res.response_byte = ID_HI;
            ST_ID2: res.response_byte = ID_LO;
            ST_SEC_HI: begin
              sector_d = {v, 8'h00};
              csum_d   = v;
              res.response_byte = BYTE_ZERO;
            end
            default: begin
              sector_d = sector_or;
              csum_d   = csum_q ^ v;
              addr_d   = base_addr[ADDR_W-1:0];
              res.response_byte = prev_q;
            end
          endcase
        end else if (eff_mode == MODE_READ) begin
          res.ack = 1'b1;
          unique case (eff_step)
            RD_ACK1: begin
              res.response_byte = CMD_ACK1;
              step_d = step_q + 4'd1;
            end
            RD_ACK2: begin
              res.response_byte = CMD_ACK2;
              step_d = step_q + 4'd1;
            end
            RD_CONF_HI: begin
              res.response_byte = sec_valid ? sector_q[15:8] : BYTE_NONE;
              step_d = step_q + 4'd1;
            end
            RD_CONF_LO: begin
              if (sec_valid) begin
                res.response_byte = sector_q[7:0];
                step_d = step_q + 4'd1;
              end else begin
                res.response_byte = BYTE_NONE;
                mode_d = MODE_IDLE;
                step_d = ST_FLAG;
              end
            end
            RD_DATA: begin
              res.response_byte = rdata_i;
              csum_d = csum_q ^ rdata_i;
              addr_d = addr_q + ADDR_W'(1);
              if (bidx_q == ByteLast) begin
                bidx_d = '0;
                step_d = step_q + 4'd1;
              end else begin
                bidx_d = bidx_q + BiW'(1);
              end
            end
            RD_SUM: begin
              res.response_byte = csum_q;
              step_d = step_q + 4'd1;
            end
            RD_END: begin
              res.response_byte = END_GOOD;
              mode_d = MODE_IDLE;
              step_d = ST_FLAG;
            end
            default: begin
              res.ack = 1'b0;
              mode_d  = MODE_IDLE;
              step_d  = ST_FLAG;
            end
          endcase
        end else if (eff_mode == MODE_WRITE) begin
          res.ack = 1'b1;
          unique case (eff_step)
            WR_DATA: begin
              mem.we = sec_valid;
              csum_d = csum_q ^ v;
              addr_d = addr_q + ADDR_W'(1);
              res.response_byte = prev_q;
              if (bidx_q == ByteLast) begin
                bidx_d = '0;
                step_d = step_q + 4'd1;
              end else begin
                bidx_d = bidx_q + BiW'(1);
              end
            end
            WR_SUM: begin
              good_d = (v == csum_q);
              res.response_byte = prev_q;
              step_d = step_q + 4'd1;
            end
            WR_ACK1: begin
              res.response_byte = CMD_ACK1;
              step_d = step_q + 4'd1;
            end
            WR_ACK2: begin
              res.response_byte = CMD_ACK2;
              step_d = step_q + 4'd1;
            end
            WR_END: begin
              if (!sec_valid) begin
                res.response_byte = BYTE_NONE;
              end else if (!good_q) begin
                res.response_byte = END_BAD_SUM;
              end else begin
                res.response_byte = END_GOOD;
              end
              mode_d = MODE_IDLE;
              step_d = ST_FLAG;
            end
            default: begin
              res.ack = 1'b0;
              mode_d  = MODE_IDLE;
              step_d  = ST_FLAG;
            end
          endcase
        end else begin
          // unused mode code
          mode_d = MODE_IDLE;
          step_d = ST_FLAG;
        end
      end
      ACT_SELECT: begin
        mode_d = MODE_IDLE;
        step_d = ST_FLAG;
      end
      ACT_INSERT: flag_d = FLAG_NEW;
      default: ;
    endcase
  end

  // Protocol state, updated once per executed word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      step_q   <= ST_FLAG;
      flag_q   <= FLAG_NEW;
      prev_q   <= BYTE_ZERO;
      sector_q <= '0;
      bidx_q   <= '0;
      csum_q   <= BYTE_ZERO;
      good_q   <= 1'b1;
      addr_q   <= '0;
    end else if (fire_i) begin
      mode_q   <= mode_d;
      step_q   <= step_d;
      flag_q   <= flag_d;
      prev_q   <= prev_d;
      sector_q <= sector_d;
      bidx_q   <= bidx_d;
      csum_q   <= csum_d;
      good_q   <= good_d;
      addr_q   <= addr_d;
    end
  end

  assign result_o = res;
  assign mem_o    = mem;
  assign addr_o   = addr_q;

endmodule

FILE: rtl/core/memory_card_sector_protocol.sv
// Channel   Direction  Handshake                 Word
// in        in         in_valid_i / in_ready_o   in_item_i  (action, host_byte)
// out       out        out_valid_o / out_ready_i out_item_o (response_byte, ack)
//
// The accept edge launches the card store read at the current byte address; the
// execute edge, once the output register can take the reply, runs the protocol
// step with the read data, writes the store and loads the output register.
// A new word is taken once the execute slot is free, while the previous reply
// may still wait in the output register.
// A full output register that is not taken holds the execute slot.
// Reset clears the sequence state; the card store keeps its contents.
`include "assert_macros.svh"

module memory_card_sector_protocol import mcsp_pkg::*; #(
  parameter int unsigned NUM_SECTORS  = NumSectorsDef,
  parameter int unsigned SECTOR_BYTES = SectorBytesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned StoreDepth = NUM_SECTORS * SECTOR_BYTES;
  localparam int unsigned AddrW      = $clog2(StoreDepth);

  logic              busy_q;
  in_item_t          item_q;
  logic              out_valid_q;
  out_item_t         out_q;
  logic              in_fire;
  logic              finish;
  out_item_t         result;
  mem_ctl_t          mem_ctl;
  logic [AddrW-1:0]  store_addr;
  logic [7:0]        rdata;
  logic              ram_we;

  // One word in execution at a time; store read issued at accept.
  assign in_ready_o = !busy_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign finish     = busy_q && (!out_valid_q || out_ready_i);
  assign ram_we     = finish && mem_ctl.we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_item_i;
    end
    if (finish) begin
      out_q <= result;
    end
  end

  mcsp_seq #(
    .NUM_SECTORS (NUM_SECTORS),
    .SECTOR_BYTES(SECTOR_BYTES),
    .ADDR_W      (AddrW)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (finish),
    .item_i  (item_q),
    .rdata_i (rdata),
    .result_o(result),
    .mem_o   (mem_ctl),
    .addr_o  (store_addr)
  );

  mcsp_ram #(
    .WIDTH(8),
    .DEPTH(StoreDepth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(store_addr),
    .wdata_i(mem_ctl.wdata),
    .re_i   (in_fire),
    .raddr_i(store_addr),
    .rdata_o(rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Store read and write never share a cycle.
  `ASSERT_IMPLIES(a_no_rw_overlap, clk_i, rst_ni, ram_we, !in_fire,
                  "store write collides with a read")
  // Without an acknowledge the reply is always the idle byte.
  `ASSERT_IMPLIES(a_nack_idle_byte, clk_i, rst_ni, out_valid_o && !out_item_o.ack,
                  out_item_o.response_byte == BYTE_NONE, "non-ack reply is not FF")
  // A new reply follows an executed word.
  `ASSERT_IMPLIES(a_reply_from_exec, clk_i, rst_ni, $rose(out_valid_q), $past(busy_q),
                  "reply without an executed word")

endmodule

FILE: dv/tb_memory_card_sector_protocol.sv
module tb_memory_card_sector_protocol;
  timeunit 1ns;
  timeprecision 1ps;
  import mcsp_pkg::*;

  typedef enum logic [1:0] {
    CARD_IDLE  = 2'd0,
    CARD_READ  = 2'd1,
    CARD_WRITE = 2'd2
  } card_mode_e;

  typedef logic [7:0] byte_q_t[$];

  localparam logic [1:0]  ACT_UNUSED  = 2'd3;
  localparam logic [7:0]  CMD_ID      = 8'h53;
  localparam int unsigned StoreSize   = NumSectorsDef * SectorBytesDef;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned SettleCycles = 20;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  memory_card_sector_protocol u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #4 clk_i = ~clk_i;

  // Card state as the host should see it
  card_mode_e  card_mode      = CARD_IDLE;
  logic [3:0]  card_step      = '0;
  logic [7:0]  card_flag      = FLAG_NEW;
  logic [7:0]  last_host_byte = '0;
  logic [15:0] cur_sector     = '0;
  int unsigned data_idx       = 0;
  logic [7:0]  xor_sum        = '0;
  bit          sum_ok         = 1'b1;
  logic [7:0]  card_image [int unsigned];
  bit          sector_full [int unsigned];
  int unsigned full_sectors [$];

  out_item_t   expected_replies [$];
  int unsigned words_sent = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  function automatic void go_idle();
    card_mode = CARD_IDLE;
    card_step = '0;
  endfunction

  function automatic bit sector_ok();
    return int'(cur_sector) < NumSectorsDef;
  endfunction

  function automatic int unsigned byte_addr();
    int unsigned a;
    a = int'(cur_sector) * SectorBytesDef + data_idx;
    return (a < StoreSize) ? a : 0;
  endfunction

  function automatic void next_data();
    data_idx++;
    if (data_idx >= SectorBytesDef) begin
      data_idx = 0;
      card_step++;
    end
  endfunction

  // Flag, ID and sector address steps common to read and write
  function automatic logic [7:0] header_reply(input logic [7:0] v);
    logic [7:0] r;
    case (card_step)
      4'd0: begin
        r = card_flag;
        data_idx = 0;
        xor_sum = '0;
      end
      4'd1: r = ID_HI;
      4'd2: r = ID_LO;
      4'd3: begin
        cur_sector = {v, 8'h00};
        xor_sum = v;
        r = BYTE_ZERO;
      end
      default: begin
        cur_sector = cur_sector | {8'h00, v};
        xor_sum = xor_sum ^ v;
        r = last_host_byte;
      end
    endcase
    card_step++;
    return r;
  endfunction

  function automatic out_item_t read_phase(input logic [7:0] v);
    out_item_t r;
    r.ack = 1'b1;
    if (card_step <= 4'd4) begin
      r.response_byte = header_reply(v);
      return r;
    end
    case (card_step)
      4'd5: begin r.response_byte = CMD_ACK1; card_step++; end
      4'd6: begin r.response_byte = CMD_ACK2; card_step++; end
      4'd7: begin
        r.response_byte = sector_ok() ? cur_sector[15:8] : BYTE_NONE;
        card_step++;
      end
      4'd8: begin
        if (sector_ok()) begin
          r.response_byte = cur_sector[7:0];
          card_step++;
        end else begin
          r.response_byte = BYTE_NONE;
          go_idle();
        end
      end
      4'd9: begin
        r.response_byte = card_image[byte_addr()];
        xor_sum = xor_sum ^ r.response_byte;
        next_data();
      end
      4'd10: begin r.response_byte = xor_sum; card_step++; end
      4'd11: begin r.response_byte = END_GOOD; go_idle(); end
      default: begin
        r.response_byte = BYTE_NONE;
        r.ack = 1'b0;
        go_idle();
      end
    endcase
    return r;
  endfunction

  function automatic out_item_t write_phase(input logic [7:0] v);
    out_item_t r;
    bit first;
    r.ack = 1'b1;
    if (card_step <= 4'd4) begin
      first = (card_step == 4'd0);
      r.response_byte = header_reply(v);
      // first write clears the new-card flag
      if (first) card_flag = card_flag & ~FLAG_NEW;
      return r;
    end
    case (card_step)
      4'd5: begin
        if (sector_ok()) card_image[byte_addr()] = v;
        xor_sum = xor_sum ^ v;
        r.response_byte = last_host_byte;
        next_data();
      end
      4'd6: begin
        sum_ok = (v == xor_sum);
        r.response_byte = last_host_byte;
        card_step++;
        if (sector_ok() && !sector_full.exists(cur_sector)) begin
          sector_full[cur_sector] = 1'b1;
          full_sectors.push_back(cur_sector);
        end
      end
      4'd7: begin r.response_byte = CMD_ACK1; card_step++; end
      4'd8: begin r.response_byte = CMD_ACK2; card_step++; end
      4'd9: begin
        if (!sector_ok()) r.response_byte = BYTE_NONE;
        else if (!sum_ok) r.response_byte = END_BAD_SUM;
        else r.response_byte = END_GOOD;
        go_idle();
      end
      default: begin
        r.response_byte = BYTE_NONE;
        r.ack = 1'b0;
        go_idle();
      end
    endcase
    return r;
  endfunction

  // Advance the card state by one word and return the reply it should give
  function automatic out_item_t card_exchange(input in_item_t w);
    out_item_t r;
    logic [7:0] v;
    v = w.host_byte;
    r.response_byte = BYTE_NONE;
    r.ack = 1'b0;
    case (w.action)
      ACT_EXCHANGE: begin
        if (card_mode == CARD_IDLE) begin
          if (v == CMD_READ) begin
            card_mode = CARD_READ;
            card_step = '0;
            r = read_phase(v);
          end else if (v == CMD_WRITE) begin
            card_mode = CARD_WRITE;
            card_step = '0;
            r = write_phase(v);
          end
        end else if (card_mode == CARD_READ) begin
          r = read_phase(v);
        end else if (card_mode == CARD_WRITE) begin
          r = write_phase(v);
        end else begin
          go_idle();
        end
        last_host_byte = v;
      end
      ACT_SELECT: go_idle();
      ACT_INSERT: card_flag = FLAG_NEW;
      default: ;
    endcase
    return r;
  endfunction

  // Send one word; a data read of a never-written byte turns into a select
  task automatic send_word(input logic [1:0] action, input logic [7:0] host_byte);
    in_item_t w;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    w.action = action;
    w.host_byte = host_byte;
    if (action == ACT_EXCHANGE && card_mode == CARD_READ && card_step == 4'd9 &&
        !card_image.exists(byte_addr()))
      w.action = ACT_SELECT;
    expected_replies.push_back(card_exchange(w));
    in_item_i = w;
    in_valid_i = 1'b1;
    words_sent++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_reply_drain();
    while (expected_replies.size() != 0) @(posedge clk_i);
  endtask

  // Select, then the first cut bytes of a sequence
  task automatic run_sequence(input byte_q_t bytes, input int unsigned cut);
    send_word(ACT_SELECT, 8'($urandom_range(0, 255)));
    foreach (bytes[i])
      if (i < cut) send_word(ACT_EXCHANGE, bytes[i]);
  endtask

  function automatic byte_q_t read_bytes(input logic [15:0] sector);
    byte_q_t q;
    q.push_back(CMD_READ);
    repeat (2) q.push_back(8'($urandom_range(0, 255)));
    q.push_back(sector[15:8]);
    q.push_back(sector[7:0]);
    repeat (4 + SectorBytesDef + 2) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  function automatic byte_q_t write_bytes(input logic [15:0] sector, input bit good);
    byte_q_t q;
    logic [7:0] sum;
    logic [7:0] d;
    q.push_back(CMD_WRITE);
    repeat (2) q.push_back(8'($urandom_range(0, 255)));
    q.push_back(sector[15:8]);
    q.push_back(sector[7:0]);
    sum = sector[15:8] ^ sector[7:0];
    repeat (SectorBytesDef) begin
      d = 8'($urandom_range(0, 255));
      sum = sum ^ d;
      q.push_back(d);
    end
    q.push_back(good ? sum : sum ^ 8'($urandom_range(1, 255)));
    repeat (3) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  function automatic logic [15:0] bad_sector();
    return 16'($urandom_range(NumSectorsDef, 16'hFFFF));
  endfunction

  // Mostly a few low sectors so that reads find written data
  function automatic logic [15:0] pick_write_sector();
    case ($urandom_range(0, 7))
      0: return 16'(NumSectorsDef - 1);
      1: return bad_sector();
      2: return 16'($urandom_range(0, NumSectorsDef - 1));
      default: return 16'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [15:0] pick_read_sector();
    if (full_sectors.size() == 0 || $urandom_range(0, 4) == 0) return bad_sector();
    return 16'(full_sectors[$urandom_range(0, full_sectors.size() - 1)]);
  endfunction

  // Non-command bytes in idle, and the unused action code
  task automatic test_command_decode();
    send_word(ACT_EXCHANGE, CMD_ID);
    send_word(ACT_EXCHANGE, 8'h00);
    send_word(ACT_EXCHANGE, 8'hFF);
    send_word(ACT_UNUSED, 8'hFF);
    send_word(ACT_UNUSED, 8'h00);
  endtask

  // Flag clear on write, insert sets it, select restarts
  task automatic test_flag_events();
    send_word(ACT_EXCHANGE, CMD_WRITE);
    send_word(ACT_SELECT, 8'h00);
    send_word(ACT_EXCHANGE, CMD_READ);
    send_word(ACT_SELECT, 8'hFF);
    send_word(ACT_INSERT, 8'h00);
    send_word(ACT_EXCHANGE, CMD_READ);
    send_word(ACT_INSERT, 8'hFF);
    send_word(ACT_EXCHANGE, 8'hA5);
    send_word(ACT_SELECT, 8'h00);
  endtask

  // Read of an out-of-range sector aborts at the sector confirmation
  task automatic test_invalid_sector();
    run_sequence(read_bytes(16'hFFFF), 9);
    send_word(ACT_EXCHANGE, 8'h00);
  endtask

  // First and last sectors, bad checksum and out-of-range write
  task automatic test_store_extremes();
    run_sequence(write_bytes(16'h0000, 1'b1), 1000);
    run_sequence(write_bytes(16'(NumSectorsDef - 1), 1'b0), 1000);
    run_sequence(write_bytes(16'hFFFF, 1'b1), 1000);
    run_sequence(write_bytes(16'(NumSectorsDef), 1'b0), 1000);
    run_sequence(read_bytes(16'h0000), 1000);
    run_sequence(read_bytes(16'(NumSectorsDef - 1)), 1000);
    run_sequence(read_bytes(16'(NumSectorsDef)), 9);
  endtask

  // Mostly whole transfers, some cut short, some noise
  task automatic test_random_traffic(input int unsigned n_words);
    int unsigned target;
    logic [15:0] s;
    target = words_sent + n_words;
    while (words_sent < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: run_sequence(write_bytes(pick_write_sector(), $urandom_range(0, 3) != 0), 1000);
        3, 4, 5: begin
          s = pick_read_sector();
          run_sequence(read_bytes(s), (int'(s) < NumSectorsDef) ? 1000 : 9);
        end
        6: begin
          if ($urandom_range(0, 1) == 1)
            run_sequence(write_bytes(pick_write_sector(), 1'b1), $urandom_range(1, 140));
          else
            run_sequence(read_bytes(pick_read_sector()), $urandom_range(1, 140));
        end
        default: begin
          repeat ($urandom_range(1, 12))
            send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  // Receiver side
  always @(negedge clk_i) out_ready_i = ($urandom_range(0, 99) >= recv_idle_pct);

  // Compare each reply with the oldest expectation
  always @(posedge clk_i) begin
    out_item_t exp_reply;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected reply byte %02h ack %0b", $realtime,
                 out_item_o.response_byte, out_item_o.ack);
        fail_count++;
      end else begin
        exp_reply = expected_replies.pop_front();
        if (out_item_o.response_byte !== exp_reply.response_byte) begin
          $display("%0t: response_byte expected %02h actual %02h", $realtime,
                   exp_reply.response_byte, out_item_o.response_byte);
          fail_count++;
        end
        if (out_item_o.ack !== exp_reply.ack) begin
          $display("%0t: ack expected %0b actual %0b", $realtime,
                   exp_reply.ack, out_item_o.ack);
          fail_count++;
        end
      end
    end
  end

  // Hang guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("FAIL memory_card_sector_protocol");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 31;
    recv_idle_pct = 74;
    test_command_decode();
    test_flag_events();
    test_invalid_sector();
    test_store_extremes();
    test_random_traffic(250);

    // sender holds off until the card has answered everything
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait_reply_drain();
    send_idle_pct = 74;
    recv_idle_pct = 31;
    test_random_traffic(250);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(250);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait_reply_drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS memory_card_sector_protocol");
    end else begin
      $display("FAIL memory_card_sector_protocol");
    end
    $finish;
  end

endmodule
